// File: design/cbq_pkg.sv
// ============================================================================
// cbq_pkg
// Shared constants, types and rounding helpers of the cascaded biquad filter.
// ============================================================================
`timescale 1ns / 1ps

package cbq_pkg;

    localparam int SAMPLE_WIDTH  = 16;
    localparam int SECTION_COUNT = 3;
    localparam int DATA_W        = 32;
    localparam int COEF_W        = 17;
    localparam int GAIN_W        = 16;
    localparam int FRAC_W        = 15;
    localparam int PROD_W        = DATA_W + COEF_W;
    localparam int ACC_W         = PROD_W + 3;
    localparam int Q_W           = ACC_W - FRAC_W;
    localparam int NUM_W         = 3 * COEF_W;
    localparam int DEN_W         = 2 * COEF_W;
    localparam int GAIN_REG_W    = 2 * GAIN_W;
    localparam int PADDR_W       = 6;
    localparam int PDATA_W       = 64;
    localparam int REG_IDX_LSB   = 3;

    localparam logic [GAIN_REG_W-1:0] GAIN_RESET = 32'h8000_8000;
    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W - FRAC_W){1'b0}}, 1'b1, {(FRAC_W - 1){1'b0}}};

    typedef enum logic [2:0] {
        REG_S1_NUM,
        REG_S1_DEN,
        REG_S2_NUM,
        REG_S2_DEN,
        REG_S3_NUM,
        REG_S3_DEN,
        REG_FRONT_GAINS,
        REG_BACK_GAINS
    } cbq_reg_t;

    typedef enum logic [2:0] {
        CELL_IDLE,
        CELL_MUL,
        CELL_ACC,
        CELL_W,
        CELL_FB,
        CELL_Y
    } cbq_cell_state_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
        logic [GAIN_W-1:0]        gain;
    } cbq_coef_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] data;
    } cbq_link_t;

    // Round half toward plus infinity and drop the fraction bits.
    function automatic logic signed [Q_W-1:0] round15(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + ROUND_HALF;
        return t[ACC_W-1:FRAC_W];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [Q_W-1:0] q);
        logic signed [DATA_W-1:0] r;
        if (q[Q_W-1:DATA_W-1] == {(Q_W - DATA_W + 1){1'b0}}
            || q[Q_W-1:DATA_W-1] == {(Q_W - DATA_W + 1){1'b1}})
        begin
            r = q[DATA_W-1:0];
        end
        else if (q[Q_W-1])
        begin
            r = {1'b1, {(DATA_W - 1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(DATA_W - 1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        input logic signed [Q_W-1:0] q);
        logic signed [SAMPLE_WIDTH-1:0] r;
        if (q[Q_W-1:SAMPLE_WIDTH-1] == {(Q_W - SAMPLE_WIDTH + 1){1'b0}}
            || q[Q_W-1:SAMPLE_WIDTH-1] == {(Q_W - SAMPLE_WIDTH + 1){1'b1}})
        begin
            r = q[SAMPLE_WIDTH-1:0];
        end
        else if (q[Q_W-1])
        begin
            r = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: design/cbq_in_if.sv
// ============================================================================
// cbq_in_if
// Input sample channel: valid/ready handshake with one signed sample.
// ============================================================================
`timescale 1ns / 1ps

interface cbq_in_if;
    import cbq_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// File: design/cbq_out_if.sv
// ============================================================================
// cbq_out_if
// Output sample channel: valid/ready handshake with one signed sample.
// ============================================================================
`timescale 1ns / 1ps

interface cbq_out_if;
    import cbq_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// File: design/cbq_cell.sv
// ============================================================================
// cbq_cell
// One biquad section in direct form II: input gain, feedback, feed-forward,
// with its own delay pair and an output register toward the next cell.
// ============================================================================
`timescale 1ns / 1ps

module cbq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  cbq_pkg::cbq_coef_t coef,
    input  cbq_pkg::cbq_link_t up_link,
    output logic               up_ready,
    output cbq_pkg::cbq_link_t dn_link,
    input  logic               dn_ready
);
    import cbq_pkg::*;

    cbq_cell_state_t state_reg, state_next;

    logic signed [DATA_W-1:0] x_reg, x_next;
    logic signed [DATA_W-1:0] xg_reg, xg_next;
    logic signed [DATA_W-1:0] w1_reg, w1_next;
    logic signed [DATA_W-1:0] w2_reg, w2_next;
    logic signed [PROD_W-1:0] pg_reg, pg_next;
    logic signed [PROD_W-1:0] pa1_reg, pa1_next;
    logic signed [PROD_W-1:0] pa2_reg, pa2_next;
    logic signed [PROD_W-1:0] pb0_reg, pb0_next;
    logic signed [PROD_W-1:0] pb1_reg, pb1_next;
    logic signed [PROD_W-1:0] pb2_reg, pb2_next;
    logic signed [ACC_W-1:0]  sa_reg, sa_next;
    logic signed [ACC_W-1:0]  sb_reg, sb_next;
    logic                     dn_valid_reg, dn_valid_next;
    logic signed [DATA_W-1:0] dn_data_reg, dn_data_next;
    logic                     slot_free;

    assign slot_free = !dn_valid_reg || dn_ready;
    assign dn_link   = '{valid: dn_valid_reg, data: dn_data_reg};

    always_comb
    begin
        state_next    = state_reg;
        x_next        = x_reg;
        xg_next       = xg_reg;
        w1_next       = w1_reg;
        w2_next       = w2_reg;
        pg_next       = pg_reg;
        pa1_next      = pa1_reg;
        pa2_next      = pa2_reg;
        pb0_next      = pb0_reg;
        pb1_next      = pb1_reg;
        pb2_next      = pb2_reg;
        sa_next       = sa_reg;
        sb_next       = sb_reg;
        dn_data_next  = dn_data_reg;
        dn_valid_next = dn_valid_reg && !dn_ready;
        up_ready      = 1'b0;

        unique case (state_reg)
            CELL_IDLE:
            begin
                up_ready = 1'b1;
                if (up_link.valid)
                begin
                    x_next     = up_link.data;
                    state_next = CELL_MUL;
                end
            end
            CELL_MUL:
            begin
                pg_next    = PROD_W'(x_reg) * PROD_W'($signed({1'b0, coef.gain}));
                pa1_next   = PROD_W'(coef.a1) * PROD_W'(w1_reg);
                pa2_next   = PROD_W'(coef.a2) * PROD_W'(w2_reg);
                pb1_next   = PROD_W'(coef.b1) * PROD_W'(w1_reg);
                pb2_next   = PROD_W'(coef.b2) * PROD_W'(w2_reg);
                state_next = CELL_ACC;
            end
            CELL_ACC:
            begin
                xg_next    = sat_data(round15(ACC_W'(pg_reg)));
                sa_next    = ACC_W'(pa1_reg) + ACC_W'(pa2_reg);
                sb_next    = ACC_W'(pb1_reg) + ACC_W'(pb2_reg);
                state_next = CELL_W;
            end
            CELL_W:
            begin
                w1_next    = sat_data(round15((ACC_W'(xg_reg) <<< FRAC_W) - sa_reg));
                w2_next    = w1_reg;
                state_next = CELL_FB;
            end
            CELL_FB:
            begin
                pb0_next   = PROD_W'(coef.b0) * PROD_W'(w1_reg);
                state_next = CELL_Y;
            end
            CELL_Y:
            begin
                if (slot_free)
                begin
                    dn_data_next  = sat_data(round15(ACC_W'(pb0_reg) + sb_reg));
                    dn_valid_next = 1'b1;
                    up_ready      = 1'b1;
                    if (up_link.valid)
                    begin
                        x_next     = up_link.data;
                        state_next = CELL_MUL;
                    end
                    else
                    begin
                        state_next = CELL_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = CELL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= CELL_IDLE;
            dn_valid_reg <= 1'b0;
            w1_reg       <= '0;
            w2_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            dn_valid_reg <= dn_valid_next;
            w1_reg       <= w1_next;
            w2_reg       <= w2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        xg_reg      <= xg_next;
        pg_reg      <= pg_next;
        pa1_reg     <= pa1_next;
        pa2_reg     <= pa2_next;
        pb0_reg     <= pb0_next;
        pb1_reg     <= pb1_next;
        pb2_reg     <= pb2_next;
        sa_reg      <= sa_next;
        sb_reg      <= sb_next;
        dn_data_reg <= dn_data_next;
    end

`ifndef SYNTHESIS
    a_accept_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (up_link.valid && up_ready) |=> (state_reg == CELL_MUL))
        else $error("cbq_cell: accepted request did not start the multiply step");

    a_delay_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != CELL_W) |=> ($stable(w1_reg) && $stable(w2_reg)))
        else $error("cbq_cell: delay pair changed outside the feedback step");

    a_result_from_y: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dn_valid_reg) |-> ($past(state_reg) == CELL_Y))
        else $error("cbq_cell: result appeared without a finished section");
`endif

endmodule

// File: design/cbq_out_stage.sv
// ============================================================================
// cbq_out_stage
// Output gain, rounding and saturation to the sample width, with the
// output register of the result channel.
// ============================================================================
`timescale 1ns / 1ps

module cbq_out_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [cbq_pkg::GAIN_W-1:0] gain,
    input  cbq_pkg::cbq_link_t      up_link,
    output logic                    up_ready,
    cbq_out_if.source               out_chan
);
    import cbq_pkg::*;

    logic                           prod_valid_reg, prod_valid_next;
    logic signed [PROD_W-1:0]       prod_reg, prod_next;
    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] out_data_reg, out_data_next;
    logic                           advance;

    assign advance  = !out_valid_reg || out_chan.ready;
    assign up_ready = !prod_valid_reg || advance;

    always_comb
    begin
        prod_next       = prod_reg;
        out_data_next   = out_data_reg;
        prod_valid_next = prod_valid_reg && !advance;
        out_valid_next  = out_valid_reg && !out_chan.ready;

        if (up_link.valid && up_ready)
        begin
            prod_next       = PROD_W'(up_link.data) * PROD_W'($signed({1'b0, gain}));
            prod_valid_next = 1'b1;
        end
        if (prod_valid_reg && advance)
        begin
            out_data_next  = sat_sample(round15(ACC_W'(prod_reg)));
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    assign out_chan.valid      = out_valid_reg;
    assign out_chan.sample_out = out_data_reg;

`ifndef SYNTHESIS
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (prod_valid_reg && !advance) |=> prod_valid_reg)
        else $error("cbq_out_stage: pending product lost while output stalled");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(prod_valid_reg))
        else $error("cbq_out_stage: output valid without a pending product");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (prod_valid_reg && out_valid_reg && !out_chan.ready) |-> !up_ready)
        else $error("cbq_out_stage: accepted a request while both stages were full");
`endif

endmodule

// File: design/cascaded_biquad_iir_filter_core.sv
// ============================================================================
// cascaded_biquad_iir_filter_core
// Three biquad sections in a chain of cells with APB coefficient registers.
// Each cell takes a new sample only in idle or in the result step of its
// five-step section sequence (products, sums, feedback, b0 product,
// result), and it waits in the result step while the next stage is full.
// Reset: delay pairs zero, coefficients zero, all gains 1.0.
// ============================================================================
`timescale 1ns / 1ps

module cascaded_biquad_iir_filter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbq_pkg::PADDR_W-1:0]   paddr,
    input  logic [cbq_pkg::PDATA_W-1:0]   pwdata,
    output logic [cbq_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    cbq_in_if.sink                        in_chan,
    cbq_out_if.source                     out_chan
);
    import cbq_pkg::*;

    logic [NUM_W-1:0]      num_reg [3];
    logic [DEN_W-1:0]      den_reg [3];
    logic [GAIN_REG_W-1:0] front_reg;
    logic [GAIN_REG_W-1:0] back_reg;
    cbq_reg_t              reg_idx;
    logic                  wr_en;

    cbq_coef_t coef [SECTION_COUNT];
    cbq_link_t link [SECTION_COUNT + 1];
    logic      link_ready [SECTION_COUNT + 1];

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = cbq_reg_t'(paddr[PADDR_W-1:REG_IDX_LSB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= '0;
                den_reg[i] <= '0;
            end
            front_reg <= GAIN_RESET;
            back_reg  <= GAIN_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_S1_NUM:      num_reg[0] <= pwdata[NUM_W-1:0];
                REG_S1_DEN:      den_reg[0] <= pwdata[DEN_W-1:0];
                REG_S2_NUM:      num_reg[1] <= pwdata[NUM_W-1:0];
                REG_S2_DEN:      den_reg[1] <= pwdata[DEN_W-1:0];
                REG_S3_NUM:      num_reg[2] <= pwdata[NUM_W-1:0];
                REG_S3_DEN:      den_reg[2] <= pwdata[DEN_W-1:0];
                REG_FRONT_GAINS: front_reg  <= pwdata[GAIN_REG_W-1:0];
                REG_BACK_GAINS:  back_reg   <= pwdata[GAIN_REG_W-1:0];
                default:         front_reg  <= front_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_S1_NUM:      prdata = PDATA_W'(num_reg[0]);
            REG_S1_DEN:      prdata = PDATA_W'(den_reg[0]);
            REG_S2_NUM:      prdata = PDATA_W'(num_reg[1]);
            REG_S2_DEN:      prdata = PDATA_W'(den_reg[1]);
            REG_S3_NUM:      prdata = PDATA_W'(num_reg[2]);
            REG_S3_DEN:      prdata = PDATA_W'(den_reg[2]);
            REG_FRONT_GAINS: prdata = PDATA_W'(front_reg);
            REG_BACK_GAINS:  prdata = PDATA_W'(back_reg);
            default:         prdata = '0;
        endcase
    end

    assign link[0]        = '{valid: in_chan.valid, data: DATA_W'(in_chan.sample_in)};
    assign in_chan.ready  = link_ready[0];

    for (genvar k = 0; k < SECTION_COUNT; k++)
    begin : g_cell
        assign coef[k].b0 = num_reg[k][COEF_W-1:0];
        assign coef[k].b1 = num_reg[k][2*COEF_W-1:COEF_W];
        assign coef[k].b2 = num_reg[k][3*COEF_W-1:2*COEF_W];
        assign coef[k].a1 = den_reg[k][COEF_W-1:0];
        assign coef[k].a2 = den_reg[k][2*COEF_W-1:COEF_W];
        if (k == 0)
        begin : g_gain0
            assign coef[k].gain = front_reg[GAIN_W-1:0];
        end
        else if (k == 1)
        begin : g_gain1
            assign coef[k].gain = front_reg[GAIN_REG_W-1:GAIN_W];
        end
        else
        begin : g_gain2
            assign coef[k].gain = back_reg[GAIN_W-1:0];
        end

        cbq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .coef     (coef[k]),
            .up_link  (link[k]),
            .up_ready (link_ready[k]),
            .dn_link  (link[k+1]),
            .dn_ready (link_ready[k+1])
        );
    end

    cbq_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .gain     (back_reg[GAIN_REG_W-1:GAIN_W]),
        .up_link  (link[SECTION_COUNT]),
        .up_ready (link_ready[SECTION_COUNT]),
        .out_chan (out_chan)
    );

endmodule

// File: tb/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the cascaded biquad filter core: APB coefficient
// loads between phases, directed extremes, then randomized filter settings
// and samples; outputs match listed results or a fixed-point filter model.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
    import cbq_pkg::*;

    typedef enum logic [3:0] {
        PRESET_KEEP,
        PRESET_PASS,
        PRESET_MAX_B0,
        PRESET_MIN_B0,
        PRESET_ZERO_GAIN,
        PRESET_ALL_ONES,
        PRESET_FILTER,
        PRESET_RANDOM_STABLE,
        PRESET_RANDOM_EXTREME,
        PRESET_RANDOM_RAW
    } preset_t;

    typedef struct packed {
        preset_t                        preset;
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           known;
        logic signed [SAMPLE_WIDTH-1:0] result;
    } vector_t;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = 16'sh8000;
    localparam int  UNITY           = 32768;
    localparam int  COEF_MAX        = 65535;
    localparam int  COEF_MIN        = -65536;
    localparam int  RANDOM_PHASES   = 8;
    localparam int  ITEMS_PER_PHASE = 106;
    localparam int  HOLD_OFF_CYCLES = 80;
    localparam int  SETTLE_CYCLES   = 8;
    localparam int  TAIL_CYCLES     = 40;
    localparam int  CYCLE_LIMIT     = 200000;

    localparam vector_t DIRECTED_ROWS [23] = '{
        '{PRESET_KEEP,      SAMPLE_MAX,    1'b1, 16'sd0},
        '{PRESET_KEEP,      SAMPLE_MIN,    1'b1, 16'sd0},
        '{PRESET_KEEP,      16'sd1,        1'b1, 16'sd0},
        '{PRESET_PASS,      SAMPLE_MAX,    1'b1, SAMPLE_MAX},
        '{PRESET_KEEP,      SAMPLE_MIN,    1'b1, SAMPLE_MIN},
        '{PRESET_KEEP,      16'sd0,        1'b1, 16'sd0},
        '{PRESET_KEEP,      -16'sd1,       1'b1, -16'sd1},
        '{PRESET_KEEP,      16'sd12345,    1'b1, 16'sd12345},
        '{PRESET_MAX_B0,    SAMPLE_MAX,    1'b1, SAMPLE_MAX},
        '{PRESET_KEEP,      SAMPLE_MIN,    1'b1, SAMPLE_MIN},
        '{PRESET_KEEP,      16'sd1,        1'b0, 16'sd0},
        '{PRESET_MIN_B0,    SAMPLE_MAX,    1'b1, SAMPLE_MIN},
        '{PRESET_KEEP,      SAMPLE_MIN,    1'b1, SAMPLE_MAX},
        '{PRESET_ZERO_GAIN, SAMPLE_MAX,    1'b1, 16'sd0},
        '{PRESET_ALL_ONES,  SAMPLE_MAX,    1'b0, 16'sd0},
        '{PRESET_KEEP,      SAMPLE_MIN,    1'b0, 16'sd0},
        '{PRESET_KEEP,      16'sd100,      1'b0, 16'sd0},
        '{PRESET_FILTER,    SAMPLE_MAX,    1'b0, 16'sd0},
        '{PRESET_KEEP,      16'sd0,        1'b0, 16'sd0},
        '{PRESET_KEEP,      16'sd0,        1'b0, 16'sd0},
        '{PRESET_KEEP,      16'sd0,        1'b0, 16'sd0},
        '{PRESET_KEEP,      SAMPLE_MIN,    1'b0, 16'sd0},
        '{PRESET_KEEP,      16'sd0,        1'b0, 16'sd0}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    cbq_in_if  in_bus ();
    cbq_out_if out_bus ();

    logic [PDATA_W-1:0]             coef_shadow [8];
    longint                         delay_line [6];
    logic signed [SAMPLE_WIDTH-1:0] expected_samples [$];
    int                             error_count = 0;
    int                             cycle_count = 0;
    int                             hold_off_requests;
    bit                             idle_on;

    cascaded_biquad_iir_filter_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_chan  (in_bus.sink),
        .out_chan (out_bus.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("cascaded_biquad_iir_filter_core verification failed");
            $finish;
        end
    end

    function automatic longint round_q15(input longint v);
        return (v + 64'sd16384) >>> FRAC_W;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint gain_field(input int idx);
        logic [PDATA_W-1:0] r;
        r = coef_shadow[int'(REG_FRONT_GAINS) + idx / 2];
        return longint'({48'h0, r[(idx % 2) * GAIN_W +: GAIN_W]});
    endfunction

    function automatic logic [PDATA_W-1:0] reg_mask(input cbq_reg_t idx);
        int width;
        case (idx)
            REG_S1_NUM, REG_S2_NUM, REG_S3_NUM: width = NUM_W;
            REG_S1_DEN, REG_S2_DEN, REG_S3_DEN: width = DEN_W;
            default:                            width = GAIN_REG_W;
        endcase
        return (64'd1 << width) - 64'd1;
    endfunction

    // Advance the three sections by one sample and return the output sample.
    function automatic logic signed [SAMPLE_WIDTH-1:0] filter_sample(
        input logic signed [SAMPLE_WIDTH-1:0] s);
        logic [PDATA_W-1:0]       num;
        logic [PDATA_W-1:0]       den;
        logic signed [COEF_W-1:0] b0, b1, b2, a1, a2;
        longint                   x, y, w, w1, w2;
        x = clamp32(round_q15(longint'(s) * gain_field(0)));
        y = 0;
        for (int k = 0; k < SECTION_COUNT; k++)
        begin
            num = coef_shadow[2 * k];
            den = coef_shadow[2 * k + 1];
            b0  = num[0 +: COEF_W];
            b1  = num[COEF_W +: COEF_W];
            b2  = num[2 * COEF_W +: COEF_W];
            a1  = den[0 +: COEF_W];
            a2  = den[COEF_W +: COEF_W];
            w1  = delay_line[2 * k];
            w2  = delay_line[2 * k + 1];
            w   = clamp32(round_q15(x * 32768 - longint'(a1) * w1 - longint'(a2) * w2));
            y   = clamp32(round_q15(longint'(b0) * w + longint'(b1) * w1
                                    + longint'(b2) * w2));
            delay_line[2 * k + 1] = w1;
            delay_line[2 * k]     = w;
            if (k + 1 < SECTION_COUNT)
                x = clamp32(round_q15(y * gain_field(k + 1)));
        end
        y = round_q15(y * gain_field(3));
        if (y > longint'(SAMPLE_MAX))
            y = longint'(SAMPLE_MAX);
        if (y < longint'(SAMPLE_MIN))
            y = longint'(SAMPLE_MIN);
        return y[SAMPLE_WIDTH-1:0];
    endfunction

    function automatic logic [PDATA_W-1:0] pack_num(input int b0, input int b1, input int b2);
        return {13'h0, 17'(b2), 17'(b1), 17'(b0)};
    endfunction

    function automatic logic [PDATA_W-1:0] pack_den(input int a1, input int a2);
        return {30'h0, 17'(a2), 17'(a1)};
    endfunction

    function automatic logic [GAIN_W-1:0] extreme_gain();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'h8000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return 16'($urandom);
        if (pick < 17)
            return 16'($urandom_range(0, 1024)) - 16'sd512;
        case ($urandom_range(0, 2))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            default: return 16'sd0;
        endcase
    endfunction

    task automatic random_stable_section(input bit wide_b, output logic [PDATA_W-1:0] num,
                                         output logic [PDATA_W-1:0] den);
        int a1, a2, lim;
        a2  = $urandom_range(0, 29000);
        lim = (a2 + 32768) * 9 / 10;
        a1  = int'($urandom_range(0, 2 * lim)) - lim;
        den = pack_den(a1, a2);
        if (wide_b)
            num = {13'h0, 51'({$urandom, $urandom})};
        else
            num = pack_num(int'($urandom_range(0, 32768)) - 16384,
                           int'($urandom_range(0, 32768)) - 16384,
                           int'($urandom_range(0, 32768)) - 16384);
    endtask

    task automatic reg_write(input cbq_reg_t idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) << REG_IDX_LSB);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        coef_shadow[idx] = value & reg_mask(idx);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_results_drained();
        in_bus.valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_preset(input preset_t p);
        logic [PDATA_W-1:0] num [3];
        logic [PDATA_W-1:0] den [3];
        logic [PDATA_W-1:0] front;
        logic [PDATA_W-1:0] back;
        if (p == PRESET_KEEP)
            return;
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        front = {32'h0, GAIN_RESET};
        back  = {32'h0, GAIN_RESET};
        for (int k = 0; k < 3; k++)
        begin
            num[k] = '0;
            den[k] = '0;
        end
        case (p)
            PRESET_PASS:
                for (int k = 0; k < 3; k++)
                    num[k] = pack_num(UNITY, 0, 0);
            PRESET_MAX_B0, PRESET_MIN_B0:
            begin
                for (int k = 0; k < 3; k++)
                    num[k] = pack_num((p == PRESET_MAX_B0) ? COEF_MAX : COEF_MIN, 0, 0);
                front = 64'hFFFF_FFFF;
                back  = 64'hFFFF_FFFF;
            end
            PRESET_ZERO_GAIN:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    num[k] = {$urandom, $urandom};
                    den[k] = {$urandom, $urandom};
                end
                front = {$urandom, 32'h0};
                back  = {$urandom, 32'h0};
            end
            PRESET_ALL_ONES:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    num[k] = '1;
                    den[k] = '1;
                end
                front = '1;
                back  = '1;
            end
            PRESET_FILTER:
            begin
                num[0] = pack_num(13302, 27480, 13302);
                den[0] = pack_den(-48511, 27480);
                num[1] = pack_num(35144, -17174, 24657);
                den[1] = pack_den(-25033, 10297);
                num[2] = pack_num(17340, -5810, 17340);
                den[2] = pack_den(-26549, 10297);
                front  = {32'h0, 16'd17340, 16'd25033};
                back   = {32'h0, 16'd13302, 16'd26549};
            end
            PRESET_RANDOM_STABLE:
            begin
                for (int k = 0; k < 3; k++)
                    random_stable_section(1'b0, num[k], den[k]);
                front = {32'h0, 16'($urandom_range(8192, 40000)),
                         16'($urandom_range(8192, 40000))};
                back  = {32'h0, 16'($urandom_range(8192, 40000)),
                         16'($urandom_range(8192, 40000))};
            end
            PRESET_RANDOM_EXTREME:
            begin
                for (int k = 0; k < 3; k++)
                    random_stable_section(1'b1, num[k], den[k]);
                front = {$urandom, extreme_gain(), extreme_gain()};
                back  = {$urandom, extreme_gain(), extreme_gain()};
            end
            default:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    num[k] = {$urandom, $urandom};
                    den[k] = {$urandom, $urandom};
                end
                front = {$urandom, $urandom};
                back  = {$urandom, $urandom};
            end
        endcase
        reg_write(REG_S1_NUM, num[0]);
        reg_write(REG_S1_DEN, den[0]);
        reg_write(REG_S2_NUM, num[1]);
        reg_write(REG_S2_DEN, den[1]);
        reg_write(REG_S3_NUM, num[2]);
        reg_write(REG_S3_DEN, den[2]);
        reg_write(REG_FRONT_GAINS, front);
        reg_write(REG_BACK_GAINS, back);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input logic known,
                               input logic signed [SAMPLE_WIDTH-1:0] fixed);
        logic signed [SAMPLE_WIDTH-1:0] predicted;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.sample_in <= s;
        do @(posedge clk); while (!in_bus.ready);
        predicted = filter_sample(s);
        expected_samples.push_back(known ? fixed : predicted);
    endtask

    task automatic check_sample(input logic signed [SAMPLE_WIDTH-1:0] got);
        logic signed [SAMPLE_WIDTH-1:0] want;
        if (expected_samples.size() == 0)
        begin
            if (error_count < 10)
                $display("unexpected output sample %0d", got);
            error_count++;
            return;
        end
        want = expected_samples.pop_front();
        if (got !== want)
        begin
            if (error_count < 10)
                $display("sample_out mismatch: expected %0d, got %0d", want, got);
            error_count++;
        end
    endtask

    initial
    begin : output_sink
        int stall_left;
        int hold_left;
        int holds_served;
        stall_left    = 0;
        hold_left     = 0;
        holds_served  = 0;
        out_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_bus.valid && out_bus.ready)
                check_sample(out_bus.sample_out);
            if (holds_served != hold_off_requests)
            begin
                holds_served = hold_off_requests;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                out_bus.ready <= 1'b0;
            end
            else
                out_bus.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        vector_t row;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_bus.valid      = 1'b0;
        in_bus.sample_in  = '0;
        hold_off_requests = 0;
        idle_on           = 1'b1;
        for (int i = 0; i < 8; i++)
            coef_shadow[i] = '0;
        coef_shadow[REG_FRONT_GAINS] = {32'h0, GAIN_RESET};
        coef_shadow[REG_BACK_GAINS]  = {32'h0, GAIN_RESET};
        for (int i = 0; i < 6; i++)
            delay_line[i] = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
        begin
            row = DIRECTED_ROWS[i];
            apply_preset(row.preset);
            send_sample(row.sample, row.known, row.result);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 4)
                0:       apply_preset(PRESET_FILTER);
                1:       apply_preset(PRESET_RANDOM_STABLE);
                2:       apply_preset(PRESET_RANDOM_RAW);
                default: apply_preset(PRESET_RANDOM_EXTREME);
            endcase
            idle_on = (phase != 3) && (phase != RANDOM_PHASES - 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // hold the output side while requests keep coming
                if (phase == 1 && n == 40)
                    hold_off_requests++;
                if (phase == 2 && n == 50)
                    wait_results_drained();
                send_sample(random_sample(), 1'b0, '0);
            end
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("cascaded_biquad_iir_filter_core verification clean");
        else
            $display("cascaded_biquad_iir_filter_core verification failed");
        $finish;
    end

endmodule

// File: files.f
design/cbq_pkg.sv
design/cbq_in_if.sv
design/cbq_out_if.sv
design/cbq_cell.sv
design/cbq_out_stage.sv
design/cascaded_biquad_iir_filter_core.sv
tb/tb_top.sv
